[sv/csa_pkg.sv]
// ----------------------------------------------------------------------------
// csa_pkg
// Shared sizes, codes and controller/datapath interface types for the
// contiguous slot allocator.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int SLOTS        = 32;
  localparam int VOICES       = 8;
  localparam int AGE_BITS     = 32;
  localparam int STEAL_ROUNDS = 8;

  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int VOICE_W  = $clog2(VOICES);
  localparam int KIND_W   = 2;
  localparam int CH_W     = 3;
  localparam int NOTE_W   = 8;
  localparam int CNT_W    = 6;
  localparam int STATUS_W = 2;
  localparam int FIRST_W  = 5;
  localparam int MASK_W   = 32;
  localparam int STOLEN_W = 4;
  // wide enough to hold a slot index plus a requested count without overflow
  localparam int SUM_W    = $clog2(SLOTS + (1 << CNT_W)) + 1;

  localparam logic [KIND_W-1:0] KIND_ALLOC       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE_ALL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_RUN    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_RECORD = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_REL_CH,
    OP_REL_ALL,
    OP_SEARCH,
    OP_SCAN_INIT,
    OP_SCAN_STEP,
    OP_DROP,
    OP_COMMIT,
    OP_FAIL,
    OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   last;   // report the result of this transaction: done is registered from it
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              run_found;
    logic              best_valid;
    logic              scan_last;
    logic              steal_limit;
  } dp_stat_t;

endpackage

[sv/contiguous_slot_allocator_lru.sv]
// ----------------------------------------------------------------------------
// contiguous_slot_allocator_lru
// First-fit contiguous slot allocator with least-recently-allocated stealing.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Its result
// appears for exactly one cycle with done high; the receiver cannot stall it,
// so capture the result ports whenever done is seen. Release and release-all
// load the request and then drop the voices, and a no-op kind loads and
// reports; an allocate that fits without stealing loads, releases the
// channel's voice, runs the first-fit search and commits, and each steal round
// adds a walk over the voice records for the oldest age, a drop of that voice,
// a first-fit search and a decision, with at most eight steals. The
// oldest-voice walk, one record per cycle, sets the length of a steal round.
// A new transaction may be issued in the same cycle that done is high.
// ----------------------------------------------------------------------------
module contiguous_slot_allocator_lru import csa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   kind,
  input  logic [CH_W-1:0]     channel,
  input  logic [NOTE_W-1:0]   note,
  input  logic [CNT_W-1:0]    slot_count,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [FIRST_W-1:0]  first_slot,
  output logic [MASK_W-1:0]   key_off_mask,
  output logic [STOLEN_W-1:0] stolen_count
);

  // controller issues one datapath command per cycle and watches its status
  dp_cmd_t  cmd;
  dp_stat_t stat;

  csa_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath holds the busy map, the voice records and the result registers
  csa_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .kind         (kind),
    .channel      (channel),
    .note         (note),
    .slot_count   (slot_count),
    .done         (done),
    .status       (status),
    .first_slot   (first_slot),
    .key_off_mask (key_off_mask),
    .stolen_count (stolen_count)
  );

endmodule

[sv/csa_datapath.sv]
// ----------------------------------------------------------------------------
// csa_datapath
// Slot busy map, voice record lanes, first-fit run search, oldest-voice scan
// and result registers, driven one command per cycle by the controller.
// ----------------------------------------------------------------------------
module csa_datapath import csa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [KIND_W-1:0]   kind,
  input  logic [CH_W-1:0]     channel,
  input  logic [NOTE_W-1:0]   note,
  input  logic [CNT_W-1:0]    slot_count,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [FIRST_W-1:0]  first_slot,
  output logic [MASK_W-1:0]   key_off_mask,
  output logic [STOLEN_W-1:0] stolen_count
);

  // latched transaction
  logic [KIND_W-1:0]  req_kind;
  logic [CH_W-1:0]    req_channel;
  logic [NOTE_W-1:0]  req_note;
  logic [CNT_W-1:0]   req_count;

  logic [SLOTS-1:0]   slot_busy;
  logic [VOICES-1:0]  voice_active;
  logic [CH_W-1:0]    voice_channel [VOICES];
  logic [NOTE_W-1:0]  voice_note    [VOICES];
  logic [SLOTS-1:0]   voice_mask    [VOICES];
  logic [AGE_BITS-1:0] voice_age    [VOICES];
  logic [AGE_BITS-1:0] age_counter;

  logic [SLOTS-1:0]    freed_acc;
  logic [STOLEN_W-1:0] stolen;
  logic                run_found;
  logic [SLOT_W-1:0]   run_start;
  logic [VOICE_W-1:0]  scan_idx;
  logic                best_valid;
  logic [VOICE_W-1:0]  best_idx;
  logic [AGE_BITS-1:0] best_age;

  logic [SLOTS-1:0]    count_mask;
  logic [SLOTS-1:0]    fit_ok;
  logic                found_c;
  logic [SLOT_W-1:0]   start_c;
  logic [VOICES-1:0]   ch_match;
  logic [VOICES-1:0]   ch_sel;
  logic [VOICES-1:0]   drop_sel;
  logic [SLOTS-1:0]    freed_now;
  logic                rec_free;
  logic [VOICE_W-1:0]  rec_idx;
  logic [SLOTS-1:0]    run_mask;
  logic                drop_op;

  // first-fit: every candidate start is checked in parallel, lowest wins
  always_comb begin
    for (int b = 0; b < SLOTS; b++) begin
      count_mask[b] = SUM_W'(b) < SUM_W'(req_count);
    end
    for (int s = 0; s < SLOTS; s++) begin
      fit_ok[s] = (req_count != '0) &&
                  ((SUM_W'(s) + SUM_W'(req_count)) <= SUM_W'(SLOTS)) &&
                  (((slot_busy >> s) & count_mask) == '0);
    end
    found_c = 1'b0;
    start_c = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (fit_ok[s]) begin
        found_c = 1'b1;
        start_c = SLOT_W'(s);
      end
    end
  end

  assign run_mask = count_mask << run_start;

  // lowest active record owned by the channel, lowest free record
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      ch_match[i] = voice_active[i] && (voice_channel[i] == req_channel);
    end
    ch_sel = ch_match & (~ch_match + 1'b1);
    rec_free = 1'b0;
    rec_idx  = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!voice_active[i]) begin
        rec_free = 1'b1;
        rec_idx  = VOICE_W'(i);
      end
    end
  end

  always_comb begin
    case (cmd.op)
      OP_REL_CH:  drop_sel = ch_sel;
      OP_DROP:    drop_sel = VOICES'(1) << best_idx;
      OP_REL_ALL: drop_sel = voice_active;
      default:    drop_sel = '0;
    endcase
    freed_now = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (drop_sel[i]) begin
        freed_now = freed_now | voice_mask[i];
      end
    end
  end

  assign drop_op = (cmd.op == OP_REL_CH) || (cmd.op == OP_DROP) || (cmd.op == OP_REL_ALL);

  assign stat.kind        = req_kind;
  assign stat.run_found   = run_found;
  assign stat.best_valid  = best_valid;
  assign stat.scan_last   = scan_idx == VOICE_W'(VOICES - 1);
  assign stat.steal_limit = stolen == STOLEN_W'(STEAL_ROUNDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy    <= '0;
      voice_active <= '0;
      age_counter  <= '0;
      done         <= 1'b0;
    end else begin
      done <= cmd.last;
      if (cmd.last) begin
        status       <= (cmd.op == OP_FAIL) ? ST_NO_RUN :
                        ((cmd.op == OP_COMMIT) && !rec_free) ? ST_NO_RECORD : ST_OK;
        first_slot   <= ((cmd.op == OP_COMMIT) && rec_free) ? FIRST_W'(run_start) : '0;
        key_off_mask <= MASK_W'(freed_acc | freed_now);
        stolen_count <= stolen;
      end
      if (drop_op) begin
        voice_active <= voice_active & ~drop_sel;
        slot_busy    <= (cmd.op == OP_REL_ALL) ? '0 : (slot_busy & ~freed_now);
        freed_acc    <= freed_acc | freed_now;
      end
      case (cmd.op)
        OP_LOAD: begin
          req_kind    <= kind;
          req_channel <= channel;
          req_note    <= note;
          req_count   <= slot_count;
          freed_acc   <= '0;
          stolen      <= '0;
          run_found   <= 1'b0;
        end
        OP_SEARCH: begin
          run_found <= found_c;
          run_start <= start_c;
        end
        OP_SCAN_INIT: begin
          scan_idx   <= '0;
          best_valid <= 1'b0;
        end
        OP_SCAN_STEP: begin
          // ties go to the later (higher) record
          if (voice_active[scan_idx] && (!best_valid || voice_age[scan_idx] <= best_age)) begin
            best_valid <= 1'b1;
            best_idx   <= scan_idx;
            best_age   <= voice_age[scan_idx];
          end
          scan_idx <= scan_idx + 1'b1;
        end
        OP_DROP: begin
          stolen <= stolen + 1'b1;
        end
        OP_COMMIT: begin
          if (rec_free) begin
            voice_active[rec_idx]  <= 1'b1;
            voice_channel[rec_idx] <= req_channel;
            voice_note[rec_idx]    <= req_note;
            voice_mask[rec_idx]    <= run_mask;
            voice_age[rec_idx]     <= age_counter;
            age_counter            <= age_counter + 1'b1;
            slot_busy              <= slot_busy | run_mask;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[sv/csa_controller.sv]
// ----------------------------------------------------------------------------
// csa_controller
// Sequences one transaction: release, search, steal rounds, commit or fail, report.
// ----------------------------------------------------------------------------
module csa_controller import csa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_CHECK,
    S_SCAN,
    S_STEAL
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.last   = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.kind)
          KIND_ALLOC: begin
            cmd.op     = OP_REL_CH;
            state_next = S_SEARCH;
          end
          KIND_RELEASE: begin
            cmd.op     = OP_REL_CH;
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end
          KIND_RELEASE_ALL: begin
            cmd.op     = OP_REL_ALL;
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end
          default: begin
            cmd.op     = OP_DONE;
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_SEARCH: begin
        cmd.op     = OP_SEARCH;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.run_found) begin
          cmd.op     = OP_COMMIT;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end else if (stat.steal_limit) begin
          cmd.op     = OP_FAIL;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_SCAN_INIT;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN_STEP;
        if (stat.scan_last) begin
          state_next = S_STEAL;
        end
      end
      S_STEAL: begin
        if (stat.best_valid) begin
          cmd.op     = OP_DROP;
          state_next = S_SEARCH;
        end else begin
          cmd.op     = OP_FAIL;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= state_next != S_IDLE;
    end
  end

endmodule

[tb/contiguous_slot_allocator_lru_tb.sv]
// ----------------------------------------------------------------------------
// contiguous_slot_allocator_lru_tb
// Self-checking bench for the first-fit slot allocator with LRU stealing.
// ----------------------------------------------------------------------------
// A scripted opening hits the corner cases: an empty map, a full-width run,
// stealing, illegal slot counts, a fill of all records, first-fit into a hole
// and release-all. Random allocate/release traffic follows with random idle
// bursts on the command side. Every result is compared against a cycle-free
// model of the voice table kept inside this bench or a hand-typed expectation.
// ----------------------------------------------------------------------------
module contiguous_slot_allocator_lru_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csa_pkg::*;

  // The fourth kind code has no name in the package: it is a no-op.
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

  localparam int RANDOM_ITEMS = 2000;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIRST_W-1:0]  first;
    logic [MASK_W-1:0]   mask;
    logic [STOLEN_W-1:0] stolen;
  } voice_result_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   channel;
    logic [NOTE_W-1:0] note;
    logic [CNT_W-1:0]  count;
    bit                typed;  // want holds a hand-written expectation
    voice_result_t     want;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [KIND_W-1:0]   op_kind = '0;
  logic [CH_W-1:0]     op_channel = '0;
  logic [NOTE_W-1:0]   op_note = '0;
  logic [CNT_W-1:0]    op_count = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] res_status;
  logic [FIRST_W-1:0]  res_first;
  logic [MASK_W-1:0]   res_mask;
  logic [STOLEN_W-1:0] res_stolen;

  contiguous_slot_allocator_lru uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (op_kind),
    .channel      (op_channel),
    .note         (op_note),
    .slot_count   (op_count),
    .done         (done),
    .status       (res_status),
    .first_slot   (res_first),
    .key_off_mask (res_mask),
    .stolen_count (res_stolen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the voice table and busy map.
  logic [SLOTS-1:0]    slot_map;
  logic                rec_active [VOICES];
  logic [CH_W-1:0]     rec_channel [VOICES];
  logic [NOTE_W-1:0]   rec_note [VOICES];
  logic [FIRST_W-1:0]  rec_first [VOICES];
  logic [CNT_W-1:0]    rec_count [VOICES];
  logic [AGE_BITS-1:0] rec_age [VOICES];
  logic [AGE_BITS-1:0] age_now;

  voice_result_t pending_results [$];
  script_row_t   script_rows [$];

  int fail_count = 0;
  int sent_count = 0;
  int placed_count = 0;
  int stolen_total = 0;
  int stolen_peak = 0;
  int missed_count = 0;
  int idle_cycles = 0;

  // Free the slots of one record and retire it; return the slots freed.
  function automatic logic [MASK_W-1:0] drop_record(input int v);
    logic [MASK_W-1:0] freed;
    int slot;
    freed = '0;
    for (int s = 0; s < int'(rec_count[v]); s++) begin
      slot = int'(rec_first[v]) + s;
      if (slot < SLOTS) freed[slot] = 1'b1;
    end
    slot_map &= ~freed;
    rec_active[v] = 1'b0;
    return freed;
  endfunction

  function automatic logic [MASK_W-1:0] release_channel(input logic [CH_W-1:0] ch);
    for (int i = 0; i < VOICES; i++) begin
      if (rec_active[i] && rec_channel[i] == ch) return drop_record(i);
    end
    return '0;
  endfunction

  // First-fit search for n contiguous free slots; -1 when there is none.
  function automatic int first_fit(input int n);
    bit clear;
    if (n < 1 || n > SLOTS) return -1;
    for (int s = 0; s + n <= SLOTS; s++) begin
      clear = 1'b1;
      for (int j = 0; j < n; j++) begin
        if (slot_map[s+j]) clear = 1'b0;
      end
      if (clear) return s;
    end
    return -1;
  endfunction

  // Oldest active record; on a tie the later index wins.
  function automatic int oldest_record();
    int best;
    logic [AGE_BITS-1:0] best_age;
    best = -1;
    best_age = '1;
    for (int i = 0; i < VOICES; i++) begin
      if (rec_active[i] && rec_age[i] <= best_age) begin
        best_age = rec_age[i];
        best = i;
      end
    end
    return best;
  endfunction

  // Apply one command to the shadow table and return what the block reports.
  function automatic voice_result_t apply_voice_op(input logic [KIND_W-1:0] k,
      input logic [CH_W-1:0] ch, input logic [NOTE_W-1:0] nt,
      input logic [CNT_W-1:0] cnt);
    voice_result_t r;
    int at;
    int v;
    int rec;
    int stolen;
    r = '0;
    stolen = 0;
    case (k)
      KIND_ALLOC: begin
        r.mask |= release_channel(ch);
        at = first_fit(int'(cnt));
        for (int round = 0; round < STEAL_ROUNDS && at < 0; round++) begin
          v = oldest_record();
          if (v < 0) break;
          r.mask |= drop_record(v);
          stolen++;
          at = first_fit(int'(cnt));
        end
        r.stolen = STOLEN_W'(stolen);
        stolen_total += stolen;
        if (stolen > stolen_peak) stolen_peak = stolen;
        if (at < 0) begin
          r.status = ST_NO_RUN;
          missed_count++;
        end else begin
          rec = -1;
          for (int i = VOICES - 1; i >= 0; i--) begin
            if (!rec_active[i]) rec = i;
          end
          if (rec < 0) begin
            r.status = ST_NO_RECORD;
          end else begin
            rec_channel[rec] = ch;
            rec_note[rec] = nt;
            rec_first[rec] = FIRST_W'(at);
            rec_count[rec] = cnt;
            rec_age[rec] = age_now;
            age_now = age_now + 1'b1;
            rec_active[rec] = 1'b1;
            for (int s = 0; s < int'(cnt); s++) slot_map[at+s] = 1'b1;
            r.status = ST_OK;
            r.first = FIRST_W'(at);
            placed_count++;
          end
        end
      end
      KIND_RELEASE: begin
        r.mask = release_channel(ch);
      end
      KIND_RELEASE_ALL: begin
        for (int i = 0; i < VOICES; i++) begin
          if (rec_active[i]) r.mask |= drop_record(i);
        end
        slot_map = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_step(input logic [KIND_W-1:0] k, input logic [CH_W-1:0] ch,
      input logic [NOTE_W-1:0] nt, input logic [CNT_W-1:0] cnt, input bit typed,
      input voice_result_t want);
    script_row_t row;
    row.kind = k;
    row.channel = ch;
    row.note = nt;
    row.count = cnt;
    row.typed = typed;
    row.want = want;
    script_rows = {script_rows, row};
  endfunction

  // Mostly small runs, some large, a few illegal sizes (zero or above 32).
  function automatic logic [CNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CNT_W'($urandom_range(1, 6));
    if (r < 85) return CNT_W'($urandom_range(7, 16));
    if (r < 95) return CNT_W'($urandom_range(17, 32));
    if (r < 97) return '0;
    return CNT_W'($urandom_range(33, 63));
  endfunction

  function automatic int pick_gap(input bit allow);
    if (!allow || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 7);
  endfunction

  // Present one command from a falling edge, hold it until the block takes it,
  // then queue its expected result. Leave start high if no gap follows.
  task automatic issue(input logic [KIND_W-1:0] k, input logic [CH_W-1:0] ch,
      input logic [NOTE_W-1:0] nt, input logic [CNT_W-1:0] cnt, input bit typed,
      input voice_result_t want, input int gap);
    voice_result_t model;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    op_kind <= k;
    op_channel <= ch;
    op_note <= nt;
    op_count <= cnt;
    do @(posedge clk); while (busy);
    model = apply_voice_op(k, ch, nt, cnt);
    if (typed) model = want;
    pending_results = {pending_results, model};
    sent_count++;
    @(negedge clk);
  endtask

  // Check each strobed result against the oldest expectation.
  always @(posedge clk) begin
    voice_result_t got;
    voice_result_t want;
    if (!rst && done) begin
      got = {res_status, res_first, res_mask, res_stolen};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result with no transaction outstanding: %p", $realtime, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.first !== want.first ||
            got.mask !== want.mask || got.stolen !== want.stolen) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: mismatch status %0d/%0d first %0d/%0d mask %h/%h stolen %0d/%0d",
                     $realtime, want.status, got.status, want.first, got.first,
                     want.mask, got.mask, want.stolen, got.stolen);
        end
      end
    end
  end

  // Abort when neither side moves a transaction for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d quiet cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    voice_result_t none;
    logic [KIND_W-1:0] k;
    int r;
    none = '0;
    slot_map = '0;
    age_now = '0;
    for (int i = 0; i < VOICES; i++) begin
      rec_active[i] = 1'b0;
      rec_channel[i] = '0;
      rec_note[i] = '0;
      rec_first[i] = '0;
      rec_count[i] = '0;
      rec_age[i] = '0;
    end

    // Opening script. Hand-typed expectations only where they are obvious.
    add_step(KIND_RELEASE, 3'd0, 8'd0, 6'd0, 1'b1, {ST_OK, 5'd0, 32'h0, 4'd0});
    add_step(KIND_NOP, 3'd7, 8'hff, 6'd63, 1'b1, {ST_OK, 5'd0, 32'h0, 4'd0});
    add_step(KIND_ALLOC, 3'd0, 8'hff, 6'd32, 1'b1, {ST_OK, 5'd0, 32'h0, 4'd0});
    // map is full: the single voice must be stolen to place one slot
    add_step(KIND_ALLOC, 3'd1, 8'h00, 6'd1, 1'b1, {ST_OK, 5'd0, 32'hffff_ffff, 4'd1});
    add_step(KIND_RELEASE, 3'd1, 8'h00, 6'd0, 1'b1, {ST_OK, 5'd0, 32'h1, 4'd0});
    // illegal sizes on an empty table: nothing to steal, no run
    add_step(KIND_ALLOC, 3'd2, 8'h5a, 6'd0, 1'b1, {ST_NO_RUN, 5'd0, 32'h0, 4'd0});
    add_step(KIND_ALLOC, 3'd3, 8'ha5, 6'd33, 1'b1, {ST_NO_RUN, 5'd0, 32'h0, 4'd0});
    add_step(KIND_ALLOC, 3'd4, 8'h3c, 6'd63, 1'b1, {ST_NO_RUN, 5'd0, 32'h0, 4'd0});
    // fill every record with four slots, then ask for the whole map
    for (int c = 0; c < VOICES; c++)
      add_step(KIND_ALLOC, CH_W'(c), NOTE_W'(c * 37), 6'd4, 1'b0, none);
    add_step(KIND_ALLOC, 3'd0, 8'h80, 6'd32, 1'b0, none);
    add_step(KIND_RELEASE_ALL, 3'd0, 8'h00, 6'd0, 1'b0, none);
    // punch a hole and let first-fit land in it
    add_step(KIND_ALLOC, 3'd1, 8'h11, 6'd3, 1'b0, none);
    add_step(KIND_ALLOC, 3'd2, 8'h22, 6'd5, 1'b0, none);
    add_step(KIND_ALLOC, 3'd3, 8'h33, 6'd2, 1'b0, none);
    add_step(KIND_RELEASE, 3'd2, 8'h00, 6'd0, 1'b0, none);
    add_step(KIND_ALLOC, 3'd4, 8'h44, 6'd5, 1'b0, none);
    // zero size with voices live: every voice gets stolen, still no run
    add_step(KIND_ALLOC, 3'd5, 8'h55, 6'd0, 1'b0, none);
    add_step(KIND_RELEASE, 3'd6, 8'h00, 6'd0, 1'b0, none);
    add_step(KIND_RELEASE_ALL, 3'd7, 8'hff, 6'd63, 1'b1, {ST_OK, 5'd0, 32'h0, 4'd0});

    // Hold reset, then release it on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script_rows[i])
      issue(script_rows[i].kind, script_rows[i].channel, script_rows[i].note,
            script_rows[i].count, script_rows[i].typed, script_rows[i].want,
            pick_gap(1'b1));

    // Random traffic: allocation-heavy so the map fills and stealing kicks in.
    // Drop the idle bursts for the last quarter to run back to back.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 72) k = KIND_ALLOC;
      else if (r < 90) k = KIND_RELEASE;
      else if (r < 95) k = KIND_RELEASE_ALL;
      else k = KIND_NOP;
      issue(k, CH_W'($urandom_range(0, VOICES - 1)), NOTE_W'($urandom_range(0, 255)),
            pick_count(), 1'b0, none, pick_gap(n < RANDOM_ITEMS * 3 / 4));
    end
    start <= 1'b0;

    // Drain outstanding results, then watch for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d transactions: %0d voices placed, %0d failed searches",
             sent_count, placed_count, missed_count);
    $display("stealing evicted %0d voices in all, at most %0d in one allocation",
             stolen_total, stolen_peak);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
